@@ src/initiator_order_tracker_defines.svh @@
// assertion macros shared by the order tracker modules
`ifndef INITIATOR_ORDER_TRACKER_DEFINES_SVH
`define INITIATOR_ORDER_TRACKER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define IOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order tracker assertion failed");

// next-cycle implication, off while reset is held
`define IOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order tracker assertion failed");

`endif

@@ src/iot_pkg.sv @@
// types and constants of the initiator order tracker
package iot_pkg;

    localparam int QUEUES_DEF     = 16;
    localparam int LIST_DEPTH_DEF = 32;
    localparam int ID_BITS_DEF    = 16;

    localparam int OP_W   = 2;
    localparam int QI_W   = 4;
    localparam int WID_W  = 16;
    localparam int KIND_W = 2;
    localparam int MODE_W = 2;

    localparam logic [OP_W-1:0] OP_SET_MODE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_INORDER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNSET   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_RELAXED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRONG  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FRONT,
        ST_SCAN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_front;
        logic emit_front;
        logic scan_start;
        logic scan;
        logic scan_end;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic            in_range;
        logic [OP_W-1:0] op;
        logic            inorder;
        logic            kind_strong;
        logic            cnt_zero;
        logic            scan_done;
    } t_dp_sts;

endpackage

@@ src/iot_ram.sv @@
// generic single-write, single-read ram with registered read data
module iot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/iot_ctrl.sv @@
// controller state machine of the order tracker
`include "initiator_order_tracker_defines.svh"

module iot_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output iot_pkg::t_dp_cmd o_cmd,
    input  iot_pkg::t_dp_sts i_sts
);
    import iot_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   need_front;
    logic   need_scan;

    assign need_front = i_sts.in_range && (i_sts.op == OP_CHECK) && i_sts.inorder
                        && i_sts.kind_strong && !i_sts.cnt_zero;
    assign need_scan  = i_sts.in_range && (i_sts.op == OP_FINISH) && i_sts.inorder
                        && !i_sts.cnt_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (need_front)     n_state = ST_FRONT;
                else if (need_scan) n_state = ST_SCAN;
                else                n_state = ST_IDLE;
            end
            ST_FRONT: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
            end
            ST_DECODE: begin
                if (need_front)     o_cmd.rd_front   = 1'b1;
                else if (need_scan) o_cmd.scan_start = 1'b1;
                else                o_cmd.exec       = 1'b1;
            end
            ST_FRONT: begin
                o_cmd.emit_front = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.scan_end = i_sts.scan_done;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `IOT_ASSERT_NXT(a_load_decodes, i_clk, i_rst_n, o_cmd.load, r_state == ST_DECODE)
    `IOT_ASSERT_NXT(a_front_one_cycle, i_clk, i_rst_n, r_state == ST_FRONT, r_state == ST_IDLE)
    `IOT_ASSERT_IMP(a_one_action, i_clk, i_rst_n, 1'b1, ($onehot0({o_cmd.exec, o_cmd.rd_front, o_cmd.emit_front, o_cmd.scan_start, o_cmd.scan_end})))

endmodule

@@ src/iot_dp.sv @@
// datapath of the order tracker: queue state, list memory, scan pipeline, result register
`include "initiator_order_tracker_defines.svh"

module iot_dp #(
    parameter int QUEUES     = iot_pkg::QUEUES_DEF,
    parameter int LIST_DEPTH = iot_pkg::LIST_DEPTH_DEF,
    parameter int ID_BITS    = iot_pkg::ID_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  iot_pkg::t_dp_cmd           i_cmd,
    output iot_pkg::t_dp_sts           o_sts,
    input  logic [iot_pkg::OP_W-1:0]   i_opcode,
    input  logic [iot_pkg::QI_W-1:0]   i_queue_index,
    input  logic [iot_pkg::WID_W-1:0]  i_work_id,
    input  logic [iot_pkg::KIND_W-1:0] i_order_kind,
    input  logic [iot_pkg::MODE_W-1:0] i_new_mode,
    output logic                       o_result_valid,
    output logic                       o_may_issue,
    output logic                       o_order_error,
    output logic                       o_list_overflow,
    output logic [iot_pkg::MODE_W-1:0] o_mode_now
);
    import iot_pkg::*;

    localparam int QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int MEMD = QUEUES * LIST_DEPTH;
    localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;
    localparam int ID_W = (ID_BITS > 16) ? 16 : ID_BITS;

    // item registers
    logic [OP_W-1:0]   r_op;
    logic [QW-1:0]     r_q;
    logic [ID_W-1:0]   r_id;
    logic [KIND_W-1:0] r_kind;
    logic [MODE_W-1:0] r_nm;
    logic              r_in_range;
    logic [AW-1:0]     r_base;

    // per-queue state
    logic [MODE_W-1:0] r_mode [QUEUES];
    logic [CW-1:0]     r_cnt  [QUEUES];

    // scan pipeline
    logic [CW-1:0] r_rd_idx;
    logic          r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    logic          r_found;

    // result register
    logic              r_valid;
    logic              r_issue;
    logic              r_err;
    logic              r_ovf;
    logic [MODE_W-1:0] r_mode_out;

    logic              load_in_range;
    logic [QW-1:0]     load_q;
    logic [MODE_W-1:0] cur_mode;
    logic [CW-1:0]     cur_cnt;
    logic [MODE_W-1:0] add_mode;
    logic              add_takes;
    logic              add_room;
    logic              add_write;
    logic              rd_more;
    logic              scan_wr;
    logic              scan_match;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ID_W-1:0]   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [ID_W-1:0]   ram_rdata;
    logic              n_issue;
    logic              n_err;
    logic              n_ovf;
    logic [MODE_W-1:0] n_mode_out;

    assign load_in_range = (32'(i_queue_index) < 32'(QUEUES));
    assign load_q        = load_in_range ? QW'(i_queue_index) : '0;

    assign cur_mode  = r_mode[r_q];
    assign cur_cnt   = r_cnt[r_q];
    assign add_mode  = (cur_mode == MODE_UNSET) ? MODE_INORDER : cur_mode;
    assign add_takes = (add_mode == MODE_INORDER)
                       && ((r_kind == KIND_RELAXED) || (r_kind == KIND_STRONG));
    assign add_room  = (cur_cnt < CW'(LIST_DEPTH));
    assign add_write = i_cmd.exec && r_in_range && (r_op == OP_ADD) && add_takes && add_room;

    // read one entry a cycle, compare the entry read last cycle
    assign rd_more    = (r_rd_idx < cur_cnt);
    assign scan_wr    = i_cmd.scan && r_cmp_vld && r_found;
    assign scan_match = i_cmd.scan && r_cmp_vld && !r_found && (ram_rdata == r_id);

    assign ram_we    = add_write || scan_wr;
    assign ram_waddr = i_cmd.scan ? AW'(r_base + AW'(r_cmp_idx) - AW'(1))
                                  : AW'(r_base + AW'(cur_cnt));
    assign ram_wdata = i_cmd.scan ? ram_rdata : r_id;
    assign ram_raddr = i_cmd.rd_front ? r_base : AW'(r_base + AW'(r_rd_idx));

    iot_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEMD)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result of an item finished in the decode cycle
    always_comb begin
        n_issue    = 1'b0;
        n_err      = 1'b0;
        n_ovf      = 1'b0;
        n_mode_out = MODE_UNSET;
        if (r_in_range) begin
            n_mode_out = cur_mode;
            case (r_op)
                OP_SET_MODE: begin
                    if (r_nm != MODE_UNSET) n_mode_out = r_nm;
                end
                OP_ADD: begin
                    n_mode_out = add_mode;
                    n_ovf      = add_takes && !add_room;
                end
                OP_FINISH: begin
                    n_mode_out = cur_mode;
                end
                OP_CHECK: begin
                    if (cur_mode == MODE_UNSET) begin
                        n_issue = 1'b0;
                    end else if (cur_mode != MODE_INORDER) begin
                        n_issue = 1'b1;
                    end else if (r_kind == KIND_RELAXED) begin
                        n_issue = 1'b1;
                        n_err   = (cur_cnt == '0);
                    end else if (r_kind == KIND_STRONG) begin
                        // front compare goes the long way, so only the empty case lands here
                        n_err = 1'b1;
                    end else begin
                        n_issue = 1'b1;
                    end
                end
                default: begin
                    n_mode_out = cur_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_id       <= ID_W'(i_work_id);
            r_kind     <= i_order_kind;
            r_nm       <= i_new_mode;
            r_base     <= AW'(32'(load_q) * 32'(LIST_DEPTH));
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= IW'(r_rd_idx);
        end
        if (i_cmd.exec) begin
            r_issue    <= n_issue;
            r_err      <= n_err;
            r_ovf      <= n_ovf;
            r_mode_out <= n_mode_out;
        end else if (i_cmd.emit_front) begin
            r_issue    <= (ram_rdata == r_id);
            r_err      <= 1'b0;
            r_ovf      <= 1'b0;
            r_mode_out <= cur_mode;
        end else if (i_cmd.scan_end) begin
            r_issue    <= 1'b0;
            r_err      <= 1'b0;
            r_ovf      <= 1'b0;
            r_mode_out <= cur_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_range <= 1'b0;
            r_q        <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
            for (int k = 0; k < QUEUES; k++) begin
                r_mode[k] <= MODE_UNSET;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_valid <= i_cmd.exec || i_cmd.emit_front || i_cmd.scan_end;
            if (i_cmd.load) begin
                r_in_range <= load_in_range;
                r_q        <= load_q;
            end
            if (i_cmd.scan_start) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_more;
                if (rd_more) r_rd_idx <= CW'(r_rd_idx + CW'(1));
                if (scan_match) r_found <= 1'b1;
            end
            if (i_cmd.exec && r_in_range) begin
                if ((r_op == OP_SET_MODE) && (r_nm != MODE_UNSET)) begin
                    r_mode[r_q] <= r_nm;
                end
                if (r_op == OP_ADD) begin
                    r_mode[r_q] <= add_mode;
                end
            end
            if (add_write) begin
                r_cnt[r_q] <= CW'(cur_cnt + CW'(1));
            end
            if (i_cmd.scan_end && r_found) begin
                r_cnt[r_q] <= CW'(cur_cnt - CW'(1));
            end
        end
    end

    assign o_sts.in_range    = r_in_range;
    assign o_sts.op          = r_op;
    assign o_sts.inorder     = (cur_mode == MODE_INORDER);
    assign o_sts.kind_strong = (r_kind == KIND_STRONG);
    assign o_sts.cnt_zero    = (cur_cnt == '0);
    assign o_sts.scan_done   = !rd_more && !r_cmp_vld;

    assign o_result_valid  = r_valid;
    assign o_may_issue     = r_issue;
    assign o_order_error   = r_err;
    assign o_list_overflow = r_ovf;
    assign o_mode_now      = r_mode_out;

    `IOT_ASSERT_IMP(a_cnt_bounded, i_clk, i_rst_n, 1'b1, 32'(cur_cnt) <= 32'(LIST_DEPTH))
    `IOT_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, (i_cmd.exec || i_cmd.emit_front || i_cmd.scan_end), r_valid)
    `IOT_ASSERT_NXT(a_finish_shrinks, i_clk, i_rst_n, (i_cmd.scan_end && r_found), cur_cnt == CW'($past(cur_cnt) - CW'(1)))

endmodule

@@ src/initiator_order_tracker.sv @@
// top level of the initiator order tracker
//
// user notes: an item is taken when start is high and busy is low; every item gives
// exactly one result, shown for one cycle with o_result_valid high, and the receiver
// cannot stall it, so it must take the result in that cycle. busy rises the cycle
// after an item is taken. set_mode, add, finish on a queue that is not in-order or
// has an empty list, checks other than a strong check against a non-empty in-order
// list, and items for a queue beyond the configured count keep busy high for one
// cycle: the result is registered from the decode state, and a new item is taken
// only once busy is low again. a strong check against a non-empty in-order list
// reads the front entry from the list memory in the decode state and compares it
// in the front state. a finish on a non-empty in-order queue walks the list through
// the single read port of the list memory, one entry a cycle, moving later entries
// down by one behind the match. the list memory needs no clearing after reset: only
// entries below a queue's fill count are ever used
module initiator_order_tracker #(
    parameter int QUEUES     = iot_pkg::QUEUES_DEF,
    parameter int LIST_DEPTH = iot_pkg::LIST_DEPTH_DEF,
    parameter int ID_BITS    = iot_pkg::ID_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [iot_pkg::OP_W-1:0]   i_opcode,
    input  logic [iot_pkg::QI_W-1:0]   i_queue_index,
    input  logic [iot_pkg::WID_W-1:0]  i_work_id,
    input  logic [iot_pkg::KIND_W-1:0] i_order_kind,
    input  logic [iot_pkg::MODE_W-1:0] i_new_mode,
    output logic                       o_result_valid,
    output logic                       o_may_issue,
    output logic                       o_order_error,
    output logic                       o_list_overflow,
    output logic [iot_pkg::MODE_W-1:0] o_mode_now
);
    import iot_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing of decode, front read and list walk
    iot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // queue modes, fill counts, list memory and the result register
    iot_dp #(
        .QUEUES     (QUEUES),
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_opcode        (i_opcode),
        .i_queue_index   (i_queue_index),
        .i_work_id       (i_work_id),
        .i_order_kind    (i_order_kind),
        .i_new_mode      (i_new_mode),
        .o_result_valid  (o_result_valid),
        .o_may_issue     (o_may_issue),
        .o_order_error   (o_order_error),
        .o_list_overflow (o_list_overflow),
        .o_mode_now      (o_mode_now)
    );

endmodule

@@ test/initiator_order_tracker_tb.sv @@
// self-checking testbench for the initiator order tracker, driven by directed and random items
`timescale 1ns / 100ps

module initiator_order_tracker_tb;

    import iot_pkg::*;

    localparam int QUEUES     = QUEUES_DEF;
    localparam int LIST_DEPTH = LIST_DEPTH_DEF;

    // order kinds and modes that the package leaves unnamed, and a second name for mode code 3
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OTHER    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_KEEP     = 2'd3;

    // slowest item is a finish on a full list after the longest sender gap
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic              may_issue;
        logic              order_error;
        logic              list_overflow;
        logic [MODE_W-1:0] mode_now;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_opcode;
    logic [QI_W-1:0]     i_queue_index;
    logic [WID_W-1:0]    i_work_id;
    logic [KIND_W-1:0]   i_order_kind;
    logic [MODE_W-1:0]   i_new_mode;
    logic                o_result_valid;
    logic                o_may_issue;
    logic                o_order_error;
    logic                o_list_overflow;
    logic [MODE_W-1:0]   o_mode_now;

    // shadow of the tracker state
    logic [MODE_W-1:0]   mode_of  [QUEUES];
    logic [WID_W-1:0]    ids_of   [QUEUES][LIST_DEPTH];
    int                  count_of [QUEUES];

    // outcomes still owed by the block, oldest first
    t_outcome            pending_outcomes [$];
    int                  mismatch_count;
    int                  idle_cycles;
    // when clear, the sender presents items back to back
    bit                  idle_on;

    initiator_order_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_queue_index   (i_queue_index),
        .i_work_id       (i_work_id),
        .i_order_kind    (i_order_kind),
        .i_new_mode      (i_new_mode),
        .o_result_valid  (o_result_valid),
        .o_may_issue     (o_may_issue),
        .o_order_error   (o_order_error),
        .o_list_overflow (o_list_overflow),
        .o_mode_now      (o_mode_now)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // one line per mismatch, and a running count
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // applies one item to the shadow state and works out the outcome it causes
    task automatic track_order(
        input  logic [OP_W-1:0]   op,
        input  logic [QI_W-1:0]   q,
        input  logic [WID_W-1:0]  id,
        input  logic [KIND_W-1:0] kind,
        input  logic [MODE_W-1:0] nm,
        output t_outcome          res
    );
        int hit;
        int i;
        res = '0;
        case (op)
            OP_SET_MODE: begin
                // code 3 leaves the mode as it was
                if (nm != MODE_KEEP)
                    mode_of[q] = nm;
            end
            OP_ADD: begin
                // an add on an unset queue makes it in-order first
                if (mode_of[q] == MODE_UNSET)
                    mode_of[q] = MODE_INORDER;
                if (mode_of[q] == MODE_INORDER &&
                    (kind == KIND_RELAXED || kind == KIND_STRONG)) begin
                    if (count_of[q] < LIST_DEPTH) begin
                        ids_of[q][count_of[q]] = id;
                        count_of[q]++;
                    end else begin
                        res.list_overflow = 1'b1;
                    end
                end
            end
            OP_FINISH: begin
                if (mode_of[q] == MODE_INORDER) begin
                    hit = -1;
                    for (i = 0; i < count_of[q]; i++)
                        if (hit < 0 && ids_of[q][i] == id)
                            hit = i;
                    // close the gap behind the first match
                    if (hit >= 0) begin
                        for (i = hit; i + 1 < count_of[q]; i++)
                            ids_of[q][i] = ids_of[q][i + 1];
                        count_of[q]--;
                    end
                end
            end
            default: begin
                if (mode_of[q] == MODE_UNSET) begin
                    res.may_issue = 1'b0;
                end else if (mode_of[q] != MODE_INORDER) begin
                    res.may_issue = 1'b1;
                end else if (kind == KIND_RELAXED) begin
                    res.may_issue   = 1'b1;
                    res.order_error = (count_of[q] == 0);
                end else if (kind == KIND_STRONG) begin
                    if (count_of[q] == 0)
                        res.order_error = 1'b1;
                    else
                        res.may_issue = (ids_of[q][0] == id);
                end else begin
                    res.may_issue = 1'b1;
                end
            end
        endcase
        res.mode_now = mode_of[q];
    endtask

    // presents one item, waits for it to be taken and records its outcome
    task automatic send_item(
        input logic [OP_W-1:0]   op,
        input logic [QI_W-1:0]   q,
        input logic [WID_W-1:0]  id,
        input logic [KIND_W-1:0] kind,
        input logic [MODE_W-1:0] nm
    );
        int       gap;
        t_outcome want;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_queue_index <= q;
        i_work_id     <= id;
        i_order_kind  <= kind;
        i_new_mode    <= nm;
        // taken at the first edge with busy low
        do @(posedge i_clk); while (busy);
        track_order(op, q, id, kind, nm, want);
        pending_outcomes.insert(pending_outcomes.size(), want);
    endtask

    // stops sending and waits until every owed outcome has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // checks, mode changes and finishes on a queue that never left unset
    task automatic test_unset_queue();
        send_item(OP_CHECK, 4'd0, 16'h0000, KIND_STRONG, MODE_INORDER);
        send_item(OP_FINISH, 4'd0, 16'h0005, KIND_RELAXED, MODE_SINGLE);
        send_item(OP_SET_MODE, 4'd0, 16'h0000, KIND_NONE, MODE_KEEP);
        wait_drained();
    endtask

    // single-lane and other modes: checks always pass, adds keep the list alone
    task automatic test_other_modes();
        send_item(OP_SET_MODE, 4'd1, 16'h0000, KIND_NONE, MODE_SINGLE);
        send_item(OP_CHECK, 4'd1, 16'h00aa, KIND_STRONG, MODE_INORDER);
        send_item(OP_SET_MODE, 4'd1, 16'h0000, KIND_NONE, MODE_KEEP);
        send_item(OP_ADD, 4'd1, 16'h0042, KIND_RELAXED, MODE_INORDER);
        send_item(OP_SET_MODE, 4'd2, 16'h0000, KIND_NONE, MODE_OTHER);
        send_item(OP_CHECK, 4'd2, 16'hffff, KIND_RESERVED, MODE_KEEP);
        wait_drained();
    endtask

    // every order kind checked against an empty in-order list
    task automatic test_empty_list_checks();
        send_item(OP_SET_MODE, 4'd3, 16'h0000, KIND_NONE, MODE_INORDER);
        send_item(OP_CHECK, 4'd3, 16'h1111, KIND_RELAXED, MODE_INORDER);
        send_item(OP_CHECK, 4'd3, 16'h2222, KIND_STRONG, MODE_INORDER);
        send_item(OP_CHECK, 4'd3, 16'h3333, KIND_NONE, MODE_INORDER);
        send_item(OP_CHECK, 4'd3, 16'h4444, KIND_RESERVED, MODE_INORDER);
        wait_drained();
    endtask

    // strong checks against the list front as entries come and go
    task automatic test_order_checks();
        send_item(OP_ADD, 4'd15, 16'hffff, KIND_RELAXED, MODE_OTHER);
        send_item(OP_ADD, 4'd15, 16'h0000, KIND_STRONG, MODE_OTHER);
        send_item(OP_ADD, 4'd15, 16'h1234, KIND_NONE, MODE_INORDER);
        send_item(OP_CHECK, 4'd15, 16'h0000, KIND_STRONG, MODE_INORDER);
        send_item(OP_CHECK, 4'd15, 16'hffff, KIND_STRONG, MODE_INORDER);
        send_item(OP_FINISH, 4'd15, 16'h5555, KIND_NONE, MODE_INORDER);
        send_item(OP_FINISH, 4'd15, 16'hffff, KIND_NONE, MODE_INORDER);
        send_item(OP_CHECK, 4'd15, 16'h0000, KIND_STRONG, MODE_INORDER);
        send_item(OP_FINISH, 4'd15, 16'h0000, KIND_STRONG, MODE_INORDER);
        send_item(OP_FINISH, 4'd15, 16'h0000, KIND_STRONG, MODE_INORDER);
        wait_drained();
    endtask

    // mixed traffic, mostly on a few busy queues, with ids taken from the lists
    task automatic test_random_traffic(input int n_items);
        int                k;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [QI_W-1:0]   q;
        logic [WID_W-1:0]  id;
        logic [KIND_W-1:0] kind;
        logic [MODE_W-1:0] nm;
        for (k = 0; k < n_items; k++) begin
            // every 40 items, pick at random whether the sender leaves gaps
            if (k % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            q    = ($urandom_range(0, 3) == 0) ? QI_W'($urandom_range(0, 15))
                                               : QI_W'($urandom_range(8, 11));
            id   = WID_W'($urandom_range(0, 65535));
            kind = KIND_W'($urandom_range(0, 3));
            nm   = MODE_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                op = OP_SET_MODE;
                if ($urandom_range(0, 9) < 7)
                    nm = MODE_INORDER;
            end else if (pick < 50) begin
                op = OP_ADD;
                if ($urandom_range(0, 9) < 8)
                    kind = ($urandom_range(0, 1) != 0) ? KIND_STRONG : KIND_RELAXED;
            end else if (pick < 75) begin
                op = OP_FINISH;
                if (count_of[q] > 0 && $urandom_range(0, 9) < 8)
                    id = ids_of[q][$urandom_range(0, count_of[q] - 1)];
            end else begin
                op = OP_CHECK;
                if ($urandom_range(0, 9) < 6)
                    kind = KIND_STRONG;
                if (count_of[q] > 0 && $urandom_range(0, 9) < 7)
                    id = ids_of[q][0];
            end
            send_item(op, q, id, kind, nm);
        end
        wait_drained();
    endtask

    // fills queues past their depth, then empties them by finishes in random order
    task automatic test_list_overflow(input int n_queues);
        int               n;
        int               k;
        logic [QI_W-1:0]  q;
        logic [WID_W-1:0] id;
        for (n = 0; n < n_queues; n++) begin
            idle_on = ($urandom_range(0, 1) != 0);
            q = QI_W'($urandom_range(0, 15));
            send_item(OP_SET_MODE, q, WID_W'($urandom_range(0, 65535)),
                      KIND_W'($urandom_range(0, 3)), MODE_INORDER);
            for (k = 0; k < LIST_DEPTH + 2; k++) begin
                id = WID_W'($urandom_range(0, 65535));
                // now and then a repeated id, so finish has to pick the first match
                if (count_of[q] > 0 && $urandom_range(0, 7) == 0)
                    id = ids_of[q][$urandom_range(0, count_of[q] - 1)];
                send_item(OP_ADD, q, id,
                          ($urandom_range(0, 1) != 0) ? KIND_STRONG : KIND_RELAXED,
                          MODE_W'($urandom_range(0, 3)));
            end
            while (count_of[q] != 0) begin
                k = $urandom_range(0, 99);
                if (k < 80) begin
                    id = ids_of[q][$urandom_range(0, count_of[q] - 1)];
                    send_item(OP_FINISH, q, id, KIND_W'($urandom_range(0, 3)),
                              MODE_W'($urandom_range(0, 3)));
                end else if (k < 90) begin
                    send_item(OP_FINISH, q, WID_W'($urandom_range(0, 65535)),
                              KIND_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)));
                end else begin
                    id = ($urandom_range(0, 1) != 0) ? ids_of[q][0] : ids_of[q][count_of[q] - 1];
                    send_item(OP_CHECK, q, id, KIND_STRONG, MODE_W'($urandom_range(0, 3)));
                end
            end
        end
        wait_drained();
    endtask

    // compares each result with the oldest owed outcome
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_result_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with nothing owed, mode_now", o_mode_now, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_may_issue !== want.may_issue)
                    report_mismatch("may_issue", o_may_issue, want.may_issue);
                if (o_order_error !== want.order_error)
                    report_mismatch("order_error", o_order_error, want.order_error);
                if (o_list_overflow !== want.list_overflow)
                    report_mismatch("list_overflow", o_list_overflow, want.list_overflow);
                if (o_mode_now !== want.mode_now)
                    report_mismatch("mode_now", o_mode_now, want.mode_now);
            end
        end
    end

    // ends a run in which nothing is taken or returned for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int q;
        mismatch_count = 0;
        idle_cycles    = 0;
        idle_on        = 1'b0;
        for (q = 0; q < QUEUES; q++) begin
            mode_of[q]  = MODE_UNSET;
            count_of[q] = 0;
        end
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_opcode      <= OP_SET_MODE;
        i_queue_index <= '0;
        i_work_id     <= '0;
        i_order_kind  <= KIND_NONE;
        i_new_mode    <= MODE_INORDER;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        idle_on = ($urandom_range(0, 1) != 0);
        test_unset_queue();
        test_other_modes();
        test_empty_list_checks();
        test_order_checks();

        // random part
        test_random_traffic(300);
        test_list_overflow(4);

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
